// ===== hw/rtl/tccw_pkg.sv =====
package tccw_pkg;

  // Geometry defaults
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Item kinds
  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Character and colour codes
  localparam logic [7:0] NEWLINE_CODE        = 8'd10;
  localparam logic [7:0] BLANK_CODE          = 8'h20;
  localparam logic [7:0] COLOR_DEFAULT_SEL   = 8'hFF;
  localparam logic [7:0] DEFAULT_COLOR_RESET = 8'd7;

  // Cell that fills the whole store after reset
  localparam logic [15:0] BLANK_RESET_CELL = {DEFAULT_COLOR_RESET, BLANK_CODE};

  // Request from the command sequencer to the screen store
  typedef struct packed {
    logic wr;      // write one cell at (row, col)
    logic rd;      // read one cell at (row, col)
    logic scroll;  // clear the top row and rotate it to the bottom
  } scr_cmd_t;

endpackage

// ===== hw/rtl/tccw_screen.sv =====
module tccw_screen #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tccw_pkg::ROWS_DEFAULT,
  parameter int ROW_W   = $clog2(ROWS),
  parameter int COL_W   = $clog2(COLUMNS)
) (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::scr_cmd_t cmd,
  input  logic [ROW_W-1:0]   row,
  input  logic [COL_W-1:0]   col,
  input  logic [15:0]        wdata,
  input  logic [7:0]         blank_color,
  output logic [15:0]        rdata,
  output logic               busy
);
  import tccw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int AW1    = ADDR_W + 1;

  typedef enum logic [1:0] {SC_INIT, SC_READY, SC_CLEAR} scr_state_t;

  scr_state_t          state;
  logic [ADDR_W-1:0]   top_base;   // physical address of logical row 0
  logic [ADDR_W-1:0]   sweep;      // address walked by init and clear passes
  logic [COL_W-1:0]    sweep_cnt;

  logic [15:0]         mem [CELLS];

  logic [AW1-1:0]      lin;
  logic [ADDR_W-1:0]   phys;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [15:0]         mem_wdata;

  // Map logical row and column onto the rotated store
  always_comb begin
    lin = AW1'(top_base) + AW1'(row) * AW1'(COLUMNS) + AW1'(col);
    if (lin >= AW1'(CELLS)) begin
      phys = ADDR_W'(lin - AW1'(CELLS));
    end else begin
      phys = ADDR_W'(lin);
    end
  end

  // Select the write source: sweep passes own the port while they run
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys;
    mem_wdata = wdata;
    case (state)
      SC_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = BLANK_RESET_CELL;
      end
      SC_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep;
        mem_wdata = {blank_color, BLANK_CODE};
      end
      SC_READY: begin
        mem_we = cmd.wr;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Store read port, registered data
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata <= mem[phys];
    end
  end

  // Sequence init pass, row clears and rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SC_INIT;
      top_base  <= '0;
      sweep     <= '0;
      sweep_cnt <= '0;
    end else begin
      case (state)
        SC_INIT: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(CELLS - 1)) begin
            state <= SC_READY;
          end
        end
        SC_READY: begin
          if (cmd.scroll) begin
            sweep     <= top_base;
            sweep_cnt <= '0;
            state     <= SC_CLEAR;
          end
        end
        SC_CLEAR: begin
          sweep     <= sweep + 1'b1;
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == COL_W'(COLUMNS - 1)) begin
            if (top_base == ADDR_W'(CELLS - COLUMNS)) begin
              top_base <= '0;
            end else begin
              top_base <= top_base + ADDR_W'(COLUMNS);
            end
            state <= SC_READY;
          end
        end
        default: begin
          state <= SC_READY;
        end
      endcase
    end
  end

  assign busy = (state != SC_READY);

endmodule

// ===== hw/rtl/text_console_cursor_writer_unit.sv =====
// Text console writer: a screen store of ROWS x COLUMNS 16-bit cells
// (character in the low byte, colour in the high byte) and a cursor.
// Input: an item is taken at a clock edge with start high and busy low.
// kind selects a put (char_code, color) or a read (read_row, read_col).
// Output: one result per item, shown for one cycle with done high; the
// receiver takes it at the edge that ends that cycle and cannot hold it off.
// Configuration: default_color_we writes default_color_wdata into the
// default colour register (used for colour 255 and for blank cells).
// Timing: done rises for a put, a newline or an out-of-range read once the
// item leaves the execute state, and for an in-range read only after the
// read state that takes the registered store data. busy falls in the
// result cycle. A put or newline that leaves the last row rotates the store
// and clears the new bottom row one cell per cycle; busy stays high through
// the result cycle until that row clear has ended.
// Reset: the cursor goes to row 0, column 0 and the default colour to 7,
// then a clearing pass writes blanks to all ROWS x COLUMNS cells, one per
// cycle, with busy high until that pass ends.
module text_console_cursor_writer_unit #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tccw_pkg::ROWS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [7:0]  char_code,
  input  logic [7:0]  color,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  input  logic        default_color_we,
  input  logic [7:0]  default_color_wdata,
  output logic        done,
  output logic [15:0] cell_data,
  output logic        cell_written,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic        scrolled
);
  import tccw_pkg::*;

  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLUMNS);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_READ} wr_state_t;

  wr_state_t        state;
  logic             kind_q;
  logic [7:0]       char_q;
  logic [7:0]       color_q;
  logic [4:0]       rrow_q;
  logic [6:0]       rcol_q;
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic [7:0]       dflt_color;

  logic             accept;
  logic             scr_busy;
  scr_cmd_t         scr_cmd;
  logic [ROW_W-1:0] scr_row;
  logic [COL_W-1:0] scr_col;
  logic [15:0]      scr_wdata;
  logic [15:0]      scr_rdata;

  logic             rd_in_range;
  logic             is_newline;
  logic             next_line;
  logic             need_scroll;
  logic [7:0]       use_color;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;

  assign busy   = (state != ST_IDLE) || scr_busy;
  assign accept = start && !busy;

  // Hold the default colour register
  always_ff @(posedge clk) begin
    if (rst) begin
      dflt_color <= DEFAULT_COLOR_RESET;
    end else if (default_color_we) begin
      dflt_color <= default_color_wdata;
    end
  end

  // Resolve colour, cursor advance and store request for the latched item
  always_comb begin
    rd_in_range = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
    is_newline  = (char_q == NEWLINE_CODE);
    use_color   = (color_q == COLOR_DEFAULT_SEL) ? dflt_color : color_q;
    next_line   = is_newline || (cur_col == COL_W'(COLUMNS - 1));
    need_scroll = next_line && (cur_row == ROW_W'(ROWS - 1));
    row_next    = cur_row;
    col_next    = cur_col + 1'b1;
    if (next_line) begin
      col_next = '0;
      if (!need_scroll) begin
        row_next = cur_row + 1'b1;
      end
    end

    scr_cmd   = '0;
    scr_wdata = {use_color, char_q};
    scr_row   = cur_row;
    scr_col   = cur_col;
    if (state == ST_EXEC) begin
      if (kind_q == KIND_READ) begin
        scr_cmd.rd = rd_in_range;
        scr_row    = ROW_W'(rrow_q);
        scr_col    = COL_W'(rcol_q);
      end else begin
        scr_cmd.wr     = !is_newline;
        scr_cmd.scroll = need_scroll;
      end
    end
  end

  tccw_screen #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ROW_W   (ROW_W),
    .COL_W   (COL_W)
  ) u_screen (
    .clk         (clk),
    .rst         (rst),
    .cmd         (scr_cmd),
    .row         (scr_row),
    .col         (scr_col),
    .wdata       (scr_wdata),
    .blank_color (dflt_color),
    .rdata       (scr_rdata),
    .busy        (scr_busy)
  );

  // Sequence one transaction and register its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur_row <= '0;
      cur_col <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_q  <= kind;
            char_q  <= char_code;
            color_q <= color;
            rrow_q  <= read_row;
            rcol_q  <= read_col;
            state   <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (kind_q == KIND_READ) begin
            cell_written <= 1'b0;
            scrolled     <= 1'b0;
            cursor_row   <= 5'(cur_row);
            cursor_col   <= 7'(cur_col);
            if (rd_in_range) begin
              state <= ST_READ;
            end else begin
              cell_data <= '0;
              done      <= 1'b1;
              state     <= ST_IDLE;
            end
          end else begin
            cur_row      <= row_next;
            cur_col      <= col_next;
            cell_data    <= is_newline ? 16'd0 : scr_wdata;
            cell_written <= !is_newline;
            scrolled     <= need_scroll;
            cursor_row   <= 5'(row_next);
            cursor_col   <= 7'(col_next);
            done         <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_READ: begin
          cell_data <= scr_rdata;
          done      <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted transaction");

  a_put_done: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_PUT) |=> ##1 done)
    else $error("put result not delivered two cycles after acceptance");

  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on consecutive cycles");

  a_scroll_col: assert property (@(posedge clk) disable iff (rst)
    done && scrolled |-> (cursor_col == 7'd0) && scr_busy)
    else $error("scroll result with cursor off column zero or no row clear");

  a_store_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> !scr_busy)
    else $error("store request issued while the store is sweeping");
`endif

endmodule
